// ----- src/pucc_pkg.sv -----
// ----------------------------------------------------------------------------
// pucc_pkg
// Types, widths and helpers shared by the periodic UV closure check.
// ----------------------------------------------------------------------------
package pucc_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int TOL_W         = FRACTION_BITS - 1;
   localparam int VAL_W         = 32;
   localparam int PER_W         = VAL_W - 1;
   localparam int QUO_W         = VAL_W + 1;
   localparam int PROD_W        = PER_W + FRACTION_BITS;
   localparam int LIFT_W        = QUO_W + 1;
   localparam int CLOSE_W       = 34;
   localparam int DIV_STAGES    = QUO_W;
   localparam int REQ_W         = 7 * VAL_W;
   localparam int RSP_W         = 72;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_PERIOD = 3'd1,
      ST_LIFT       = 3'd2,
      ST_AMBIGUOUS  = 3'd3,
      ST_DISCONT    = 3'd4,
      ST_WINDING    = 3'd5
   } status_type;

   typedef struct packed {
      logic              bad;
      logic              neg1;
      logic              negl;
      logic              negc;
      logic [QUO_W-1:0]  ad1;
      logic [QUO_W-1:0]  adl;
      logic [QUO_W-1:0]  adc;
      logic [PER_W-1:0]  per;
      logic [PROD_W-1:0] tp;
      logic [PROD_W-1:0] hp;
      logic [VAL_W-1:0]  rec1;
      logic [VAL_W-1:0]  recl;
      logic [VAL_W-1:0]  last_lifted;
   } item_type;

   typedef struct packed {
      logic [PER_W-1:0] rem;
      logic [QUO_W-1:0] shr;
   } lane_type;

   typedef struct packed {
      logic              bad;
      logic              neg1;
      logic              negl;
      logic              negc;
      logic [PER_W-1:0]  per;
      logic [PROD_W-1:0] tp;
      logic [PROD_W-1:0] hp;
      logic [VAL_W-1:0]  rec1;
      logic [VAL_W-1:0]  recl;
      logic [VAL_W-1:0]  last_lifted;
      lane_type          l1;
      lane_type          ll;
      lane_type          lc;
   } pipe_type;

   typedef struct packed {
      status_type              status;
      logic signed [CLOSE_W-1:0] closing;
      logic signed [VAL_W-1:0]   crossed;
   } result_type;

   // one restoring division step
   function automatic lane_type lane_step(lane_type l, logic [PER_W-1:0] per);
      logic [PER_W:0] trial;
      lane_type       r;
      trial = {l.rem, l.shr[QUO_W-1]};
      if (trial >= {1'b0, per}) begin
         r.rem = PER_W'(trial - {1'b0, per});
         r.shr = {l.shr[QUO_W-2:0], 1'b1};
      end else begin
         r.rem = trial[PER_W-1:0];
         r.shr = {l.shr[QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic pipe_type pipe_step(pipe_type p);
      pipe_type r;
      r    = p;
      r.l1 = lane_step(p.l1, p.per);
      r.ll = lane_step(p.ll, p.per);
      r.lc = lane_step(p.lc, p.per);
      return r;
   endfunction

endpackage

// ----- src/pucc_front.sv -----
// ----------------------------------------------------------------------------
// pucc_front
// Classifies a request: period check, magnitudes and signs of the three
// differences, and the tolerance products of the period.
// ----------------------------------------------------------------------------
module pucc_front import pucc_pkg::*; (
   input  logic [TOL_W-1:0] tol,
   input  logic [REQ_W-1:0] req_data,
   output item_type         item
);

   logic signed [VAL_W-1:0] period;
   logic signed [VAL_W-1:0] first_raw;
   logic signed [VAL_W-1:0] last_raw;
   logic signed [VAL_W-1:0] first_lifted;
   logic signed [VAL_W-1:0] last_lifted;
   logic signed [QUO_W-1:0] d1;
   logic signed [QUO_W-1:0] dl;
   logic signed [QUO_W-1:0] dc;
   logic [FRACTION_BITS-1:0] half_minus_tol;

   assign period       = req_data[0*VAL_W +: VAL_W];
   assign first_raw    = req_data[1*VAL_W +: VAL_W];
   assign last_raw     = req_data[2*VAL_W +: VAL_W];
   assign first_lifted = req_data[3*VAL_W +: VAL_W];
   assign last_lifted  = req_data[4*VAL_W +: VAL_W];

   assign d1 = QUO_W'(first_lifted) - QUO_W'(first_raw);
   assign dl = QUO_W'(last_lifted) - QUO_W'(last_raw);
   assign dc = QUO_W'(last_lifted) - QUO_W'(first_raw);

   assign half_minus_tol = {1'b1, {TOL_W{1'b0}}} - {1'b0, tol};

   always_comb begin
      item.bad         = period[VAL_W-1] | (period == '0);
      item.neg1        = d1[QUO_W-1];
      item.negl        = dl[QUO_W-1];
      item.negc        = dc[QUO_W-1];
      item.ad1         = d1[QUO_W-1] ? QUO_W'(-d1) : QUO_W'(d1);
      item.adl         = dl[QUO_W-1] ? QUO_W'(-dl) : QUO_W'(dl);
      item.adc         = dc[QUO_W-1] ? QUO_W'(-dc) : QUO_W'(dc);
      item.per         = period[PER_W-1:0];
      item.tp          = PROD_W'(tol * period[PER_W-1:0]);
      item.hp          = PROD_W'(half_minus_tol * period[PER_W-1:0]);
      item.rec1        = req_data[5*VAL_W +: VAL_W];
      item.recl        = req_data[6*VAL_W +: VAL_W];
      item.last_lifted = last_lifted;
   end

endmodule

// ----- src/pucc_queue.sv -----
// ----------------------------------------------------------------------------
// pucc_queue
// Short show-ahead queue between the front and the back.
// ----------------------------------------------------------------------------
module pucc_queue import pucc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type din,
   input  logic     pop,
   output item_type dout,
   output logic     full,
   output logic     empty
);

   item_type          mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- src/pucc_back.sv -----
// ----------------------------------------------------------------------------
// pucc_back
// Three pipelined restoring dividers, rounding, the lift checks and the
// result register.
// ----------------------------------------------------------------------------
module pucc_back import pucc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  item_type   head,
   input  logic       head_valid,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type result
);

   typedef struct packed {
      logic                      bad;
      logic [PER_W-1:0]          per;
      logic [PROD_W-1:0]         tp;
      logic [PROD_W-1:0]         hp;
      logic [VAL_W-1:0]          rec1;
      logic [VAL_W-1:0]          recl;
      logic [VAL_W-1:0]          last_lifted;
      logic signed [LIFT_W-1:0]  n1;
      logic signed [LIFT_W-1:0]  nl;
      logic signed [LIFT_W-1:0]  nc;
      logic [PER_W-1:0]          a1;
      logic [PER_W-1:0]          al;
      logic [PER_W-1:0]          ac;
      logic signed [VAL_W-1:0]   rc;
   } round_type;

   logic                  adv;
   pipe_type              s0;
   pipe_type              stg_ff [DIV_STAGES];
   pipe_type              stg_in [DIV_STAGES];
   logic [DIV_STAGES-1:0] vld_ff;
   round_type             rnd_ff, rnd_in;
   logic                  rnd_v_ff;
   result_type            res_ff, res_in;
   logic                  res_v_ff;

   assign adv       = !res_v_ff || out_ready;
   assign pop       = adv && head_valid;
   assign out_valid = res_v_ff;
   assign result    = res_ff;

   always_comb begin
      s0.bad         = head.bad;
      s0.neg1        = head.neg1;
      s0.negl        = head.negl;
      s0.negc        = head.negc;
      s0.per         = head.per;
      s0.tp          = head.tp;
      s0.hp          = head.hp;
      s0.rec1        = head.rec1;
      s0.recl        = head.recl;
      s0.last_lifted = head.last_lifted;
      s0.l1          = '{rem: '0, shr: head.ad1};
      s0.ll          = '{rem: '0, shr: head.adl};
      s0.lc          = '{rem: '0, shr: head.adc};
      stg_in[0]      = pipe_step(s0);
      for (int k = 1; k < DIV_STAGES; k++) begin
         stg_in[k] = pipe_step(stg_ff[k-1]);
      end
   end

   // round half away from zero: bump when twice the remainder reaches p
   function automatic void round_lane(input lane_type l, input logic [PER_W-1:0] per,
                                      input logic neg,
                                      output logic signed [LIFT_W-1:0] n,
                                      output logic [PER_W-1:0] a);
      logic                up;
      logic [LIFT_W-1:0]   mag;
      up  = ({l.rem, 1'b0} >= {1'b0, per});
      mag = {1'b0, l.shr} + LIFT_W'(up);
      a   = up ? PER_W'(per - l.rem) : l.rem;
      n   = neg ? -$signed(mag) : $signed(mag);
   endfunction

   always_comb begin
      pipe_type t;
      logic     upc;
      t                  = stg_ff[DIV_STAGES-1];
      upc                = ({t.lc.rem, 1'b0} >= {1'b0, t.per});
      rnd_in.bad         = t.bad;
      rnd_in.per         = t.per;
      rnd_in.tp          = t.tp;
      rnd_in.hp          = t.hp;
      rnd_in.rec1        = t.rec1;
      rnd_in.recl        = t.recl;
      rnd_in.last_lifted = t.last_lifted;
      round_lane(t.l1, t.per, t.neg1, rnd_in.n1, rnd_in.a1);
      round_lane(t.ll, t.per, t.negl, rnd_in.nl, rnd_in.al);
      round_lane(t.lc, t.per, t.negc, rnd_in.nc, rnd_in.ac);
      // signed remainder is negative when the sign and the round-up differ
      rnd_in.rc = (t.negc ^ upc) ? -$signed({1'b0, rnd_in.ac}) : $signed({1'b0, rnd_in.ac});
   end

   always_comb begin
      logic                      amb1, off1, offl, ambc, eq1, eql, cont;
      logic [PROD_W-1:0]         sh1, shl, shc;
      logic signed [CLOSE_W-1:0] cl;
      logic signed [LIFT_W:0]    pc;
      sh1  = {rnd_ff.a1, {FRACTION_BITS{1'b0}}};
      shl  = {rnd_ff.al, {FRACTION_BITS{1'b0}}};
      shc  = {rnd_ff.ac, {FRACTION_BITS{1'b0}}};
      amb1 = sh1 >= rnd_ff.hp;
      off1 = sh1 > rnd_ff.tp;
      offl = shl > rnd_ff.tp;
      ambc = shc >= rnd_ff.hp;
      eq1  = rnd_ff.n1 == LIFT_W'($signed(rnd_ff.rec1));
      eql  = rnd_ff.nl == LIFT_W'($signed(rnd_ff.recl));
      cont = {rnd_ff.ac, 1'b0} < {1'b0, rnd_ff.per};
      cl   = CLOSE_W'($signed(rnd_ff.last_lifted)) - CLOSE_W'(rnd_ff.rc);
      pc   = (LIFT_W+1)'(rnd_ff.nc) - (LIFT_W+1)'(rnd_ff.n1);
      res_in.closing = '0;
      res_in.crossed = '0;
      priority if (rnd_ff.bad) begin
         res_in.status = ST_BAD_PERIOD;
      end else if (amb1 || off1 || !eq1 || offl || !eql) begin
         res_in.status = ST_LIFT;
      end else if (ambc) begin
         res_in.status = ST_AMBIGUOUS;
      end else if (!cont) begin
         res_in.status = ST_DISCONT;
      end else if (off1) begin
         res_in.status = ST_WINDING;
      end else begin
         res_in.status  = ST_OK;
         res_in.closing = cl;
         if (pc > (LIFT_W+1)'(32'sh7FFF_FFFF)) begin
            res_in.crossed = 32'sh7FFF_FFFF;
         end else if (pc < -(LIFT_W+1)'(33'sh0_8000_0000)) begin
            res_in.crossed = 32'sh8000_0000;
         end else begin
            res_in.crossed = pc[VAL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         rnd_v_ff <= 1'b0;
         res_v_ff <= 1'b0;
      end else if (adv) begin
         vld_ff   <= {vld_ff[DIV_STAGES-2:0], head_valid};
         rnd_v_ff <= vld_ff[DIV_STAGES-1];
         res_v_ff <= rnd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            stg_ff[k] <= stg_in[k];
         end
         rnd_ff <= rnd_in;
         res_ff <= res_in;
      end
   end

endmodule

// ----- src/periodic_uv_closure_check.sv -----
// ----------------------------------------------------------------------------
// periodic_uv_closure_check
// Requests pass the queue, the 33-stage pipelined dividers, the round register
// and the result register; one request per cycle unless rsp_tready stalls.
// A four-entry queue lets the front keep accepting while the back stalls.
// Reset (synchronous, active high) empties queue and pipeline and clears
// the ambiguity tolerance to 0.
// ----------------------------------------------------------------------------
module periodic_uv_closure_check import pucc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [TOL_W-1:0] csr_wr_data,
   input  logic             req_tvalid,
   output logic             req_tready,
   // period, first_raw, last_raw, first_lifted, last_lifted,
   // recorded_first_lift, recorded_last_lift (32 bits each)
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status[2:0], closing_lifted[36:3], periods_crossed[68:37], zero pad
   output logic [RSP_W-1:0] rsp_tdata
);

   logic [TOL_W-1:0] tol_ff;
   item_type         front_item;
   item_type         head;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;
   logic             push;
   result_type       result;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   pucc_front u_front (
      .tol      (tol_ff),
      .req_data (req_tdata),
      .item     (front_item)
   );

   pucc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (front_item),
      .pop   (q_pop),
      .dout  (head),
      .full  (q_full),
      .empty (q_empty)
   );

   pucc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!q_empty),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {(RSP_W-3-CLOSE_W-VAL_W)'(0), result.crossed, result.closing,
                       result.status};

endmodule

// ----- bench/tb_periodic_uv_closure_check.sv -----
// ----------------------------------------------------------------------------
// tb_periodic_uv_closure_check
// Self-checking bench for the periodic UV closure check: directed endpoint
// and status cases, then random loops, mostly consistent, over several
// tolerance settings and idle/stall phases, checked against a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_periodic_uv_closure_check import pucc_pkg::*; ();

   typedef struct packed {
      logic signed [31:0] rec_last;
      logic signed [31:0] rec_first;
      logic signed [31:0] last_lifted;
      logic signed [31:0] first_lifted;
      logic signed [31:0] last_raw;
      logic signed [31:0] first_raw;
      logic signed [31:0] period;
   } loop_req_type;

   // crossed[68:37], closing[36:3], status[2:0]
   typedef struct packed {
      logic signed [31:0] crossed;
      logic signed [33:0] closing;
      logic [2:0]         status;
   } closure_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [TOL_W-1:0] csr_wr_data = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   periodic_uv_closure_check i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   loop_req_type pending_q[$];
   closure_type  closure_q[$];
   logic [14:0] tol_model = '0;
   int  send_idle = 0, recv_stall = 0;
   int  mismatches = 0, n_checked = 0, n_sent = 0, idle_cycles = 0;
   int  status_seen[6];

   // exact nearest-integer quotient, half away from zero
   function automatic longint round_lift(longint d, longint p, output longint rem);
      longint ad, n;
      ad = d < 0 ? -d : d;
      n  = (2 * ad + p) / (2 * p);
      if (d < 0) n = -n;
      rem = d - n * p;
      return n;
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic closure_type predict_closure(loop_req_type r, logic [14:0] tol);
      closure_type c;
      longint p, t, r1, rl, rc, n1, nl, nc, cl, pc;
      bit amb1, off1, offl, ambc;
      c = '0;
      p = r.period;
      t = tol;
      if (p <= 0) begin
         c.status = ST_BAD_PERIOD;
         return c;
      end
      n1 = round_lift(longint'(r.first_lifted) - r.first_raw, p, r1);
      nl = round_lift(longint'(r.last_lifted) - r.last_raw, p, rl);
      nc = round_lift(longint'(r.last_lifted) - r.first_raw, p, rc);
      amb1 = (mag(r1) << 16) >= (32768 - t) * p;
      off1 = (mag(r1) << 16) > t * p;
      offl = (mag(rl) << 16) > t * p;
      ambc = (mag(rc) << 16) >= (32768 - t) * p;
      if (amb1 || off1 || n1 != longint'(r.rec_first)) c.status = ST_LIFT;
      else if (offl || nl != longint'(r.rec_last)) c.status = ST_LIFT;
      else if (ambc) c.status = ST_AMBIGUOUS;
      else begin
         cl = longint'(r.last_lifted) - rc;
         if (!(2 * mag(cl - r.last_lifted) < p)) c.status = ST_DISCONT;
         else begin
            pc = nc - n1;
            if (pc > 64'sd2147483647) pc = 64'sd2147483647;
            if (pc < -64'sd2147483648) pc = -64'sd2147483648;
            c.status  = ST_OK;
            c.closing = cl[33:0];
            c.crossed = pc[31:0];
         end
      end
      return c;
   endfunction

   // consistent loop: lifts and offsets chosen within tolerance unless wild is set
   function automatic loop_req_type make_loop(logic [14:0] tol, bit wild);
      loop_req_type r;
      longint p, n1, nl, e1, el, lim;
      int sz;
      sz = $urandom_range(0, 3);
      case (sz)
         0: p = $urandom_range(1, 255);
         1: p = $urandom_range(1, 32'h0001_0000);
         2: p = $urandom_range(1, 32'h0100_0000);
         default: p = $urandom_range(1, 32'h7fff_ffff);
      endcase
      r.period    = 32'(p);
      r.first_raw = $urandom;
      r.last_raw  = $urandom;
      lim = (longint'(tol) * p) >> 16;
      n1 = longint'($urandom_range(0, 8)) - 4;
      nl = longint'($urandom_range(0, 8)) - 4;
      if (p < 64) begin
         n1 = n1 * longint'($urandom_range(1, 1000000));
         nl = nl * longint'($urandom_range(1, 1000000));
      end
      e1 = lim > 0 ? longint'($urandom_range(0, 32'(2 * lim))) - lim : 0;
      el = lim > 0 ? longint'($urandom_range(0, 32'(2 * lim))) - lim : 0;
      if (wild) begin
         e1 = e1 + longint'($urandom_range(0, 32'(p)));
         el = el + longint'($urandom_range(0, 32'(p)));
      end
      r.first_lifted = 32'(longint'(r.first_raw) + n1 * p + e1);
      r.last_lifted  = 32'(longint'(r.last_raw) + nl * p + el);
      // recompute records so most items are consistent even after wrap
      begin
         longint rem;
         r.rec_first = 32'(round_lift(longint'(r.first_lifted) - r.first_raw, p, rem));
         r.rec_last  = 32'(round_lift(longint'(r.last_lifted) - r.last_raw, p, rem));
      end
      if ($urandom_range(0, 19) == 0) r.rec_first = r.rec_first + 1;
      if ($urandom_range(0, 19) == 0) r.rec_last  = r.rec_last - 1;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // predictor taps accepted requests
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         closure_q = {closure_q, predict_closure(loop_req_type'(req_tdata), tol_model)};
         n_sent++;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= $urandom_range(0, 99) >= recv_stall;
   end

   // monitor
   always @(posedge clock) begin
      closure_type got, exp_c;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[68:0];
         if (closure_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            exp_c = closure_q.pop_front();
            n_checked++;
            if (exp_c.status < 6) status_seen[exp_c.status]++;
            if (got !== exp_c || rsp_tdata[RSP_W-1:69] !== '0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: status exp %0d got %0d, closing exp %0d got %0d,",
                            " crossed exp %0d got %0d"},
                           exp_c.status, got.status, exp_c.closing, got.closing,
                           exp_c.crossed, got.crossed);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_tol(logic [14:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      tol_model   <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic drain();
      while (pending_q.size() > 0 || req_tvalid || closure_q.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic add_direct(logic signed [31:0] p, f_raw, l_raw, f_lift, l_lift,
                             rf, rl);
      loop_req_type r;
      r.period = p; r.first_raw = f_raw; r.last_raw = l_raw;
      r.first_lifted = f_lift; r.last_lifted = l_lift;
      r.rec_first = rf; r.rec_last = rl;
      pending_q = {pending_q, r};
   endtask

   initial begin
      int phase_idle[4] = '{0, 86, 0, 38};
      int phase_stall[4] = '{0, 0, 86, 38};
      logic [14:0] tols[5] = '{15'd0, 15'd32767, 15'd1, 15'd16384, 15'd5000};
      loop_req_type r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // directed: reset tolerance 0
      add_direct(0, 1, 2, 3, 4, 5, 6);
      add_direct(32'sh8000_0000, 0, 0, 0, 0, 0, 0);
      add_direct(-1, 7, 7, 7, 7, 0, 0);
      add_direct(32'sh0001_0000, 0, 0, 32'sh0003_0000, 32'sh0003_0000, 3, 3);
      add_direct(32'sh0001_0000, 0, 0, 32'sh0000_8000, 0, 1, 0);
      add_direct(32'sh0001_0000, 0, 0, 32'sh0002_0000, 32'sh0002_0000, 1, 2);
      add_direct(32'sh0001_0000, 0, 32'sh0000_8000, 0, 32'sh0000_8000, 0, 0);
      add_direct(1, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 32'sh8000_0000, -1, -1);
      add_direct(1, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                 32'sh8000_0000, 32'sh7fff_ffff, 0);
      add_direct(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                 32'sh8000_0000, 32'sh7fff_ffff, 0, 0);
      add_direct(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh7fff_ffff, -1, 1);
      add_direct(3, 0, 0, -32'sd1, 32'sd1, 0, 0);
      add_direct(2, 0, 0, 1, -1, 1, -1);
      add_direct(-32'sd5, 32'sh7fff_ffff, 0, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff);
      drain();
      foreach (tols[k]) begin
         write_tol(tols[k]);
         if (k == 1) begin
            add_direct(32'sh0001_0000, 0, 0, 32'sh0000_4000, 32'sh0000_c000, 0, 1);
            add_direct(32'sh0001_0000, 0, 0, 0, 32'sh0000_8000, 0, 1);
         end
         for (int ph = 0; ph < 4; ph++) begin
            send_idle  = phase_idle[ph];
            recv_stall = phase_stall[ph];
            for (int i = 0; i < 85; i++) begin
               if ($urandom_range(0, 9) < 8) r = make_loop(tols[k], $urandom_range(0, 5) == 0);
               else r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
               pending_q = {pending_q, r};
            end
            drain();
         end
      end
      $display("Covered %0d requests (%0d checked) over 5 tolerance settings",
               n_sent, n_checked);
      $display("and 4 idle/stall phases; status counts ok %0d period %0d lift %0d",
               status_seen[0], status_seen[1], status_seen[2]);
      $display("ambiguous %0d discont %0d winding %0d",
               status_seen[3], status_seen[4], status_seen[5]);
      if (mismatches == 0 && closure_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/pucc_pkg.sv
src/pucc_front.sv
src/pucc_queue.sv
src/pucc_back.sv
src/periodic_uv_closure_check.sv
bench/tb_periodic_uv_closure_check.sv
